### hw/rtl/tfmd_pkg.sv
// ----------------------------------------------------------------------------
// tfmd_pkg
// Shared types and constants for the target-follow motor drive block.
// ----------------------------------------------------------------------------
package tfmd_pkg;

    // Register map, index = paddr[4:2]
    localparam int unsigned RegAddrW = 5;
    localparam logic [2:0] REG_ROT_BAND  = 3'd0;
    localparam logic [2:0] REG_DIST_LOW  = 3'd1;
    localparam logic [2:0] REG_DIST_HIGH = 3'd2;
    localparam logic [2:0] REG_ROT_GAIN  = 3'd3;
    localparam logic [2:0] REG_DIST_GAIN = 3'd4;
    localparam logic [2:0] REG_SLOWDOWN  = 3'd5;
    localparam logic [2:0] REG_R_SCALE   = 3'd6;
    localparam logic [2:0] REG_STILL_LIM = 3'd7;

    // Magnitude below which a target counts as absent
    localparam logic [16:0] NearZeroLsb = 17'd41;
    localparam int unsigned FracBits    = 12;

    // Shared multiplier widths
    localparam int unsigned MulAW   = 20;
    localparam int unsigned MulBW   = 16;
    localparam int unsigned MulSubW = 28;
    localparam int unsigned MulResW = MulAW + MulBW + 1;

    typedef struct packed {
        logic [14:0] rotation_band;
        logic [14:0] distance_low;
        logic [14:0] distance_high;
        logic [15:0] rotation_gain;
        logic [15:0] distance_gain;
        logic [15:0] approach_slowdown;
        logic [8:0]  right_scale;
        logic [3:0]  still_count_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ACT_STALLED   = 3'd0,
        ACT_NO_TARGET = 3'd1,
        ACT_STOPPED   = 3'd2,
        ACT_TURN_POS  = 3'd3,
        ACT_TURN_NEG  = 3'd4,
        ACT_FORWARD   = 3'd5,
        ACT_BACK      = 3'd6,
        ACT_IN_BAND   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_SPEED,
        ST_MUL_SCALE,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/target_follow_motor_drive.sv
// From input accept to result valid the sequencer steps through decide, two
// passes through the single shared multiply-subtract unit and the output load,
// and takes no new item until the last has gone to the output register. The
// input stalls while an item is in work, which includes waiting in the done
// state while a held result blocks the load. Synchronous active-low reset clears
// the stop latch, the previous sample, the unchanged-sample count and restores register defaults.
// ----------------------------------------------------------------------------
// target_follow_motor_drive
// Turns tracked-target measurements into left and right wheel drive.
// ----------------------------------------------------------------------------
module target_follow_motor_drive #(
    parameter int SPEED_LIMIT = 5000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfmd_pkg::RegAddrW-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_stop_request,
    input  logic                            i_go_request,
    input  logic signed [15:0]              i_rotation,
    input  logic signed [15:0]              i_distance,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [13:0]              o_motor_right,
    output logic signed [13:0]              o_motor_left,
    output logic [2:0]                      o_action
);
    import tfmd_pkg::*;

    localparam logic signed [22:0] Lim = 23'(SPEED_LIMIT);

    t_cfg    cfg;
    t_state  r_state, n_state;

    // item registers
    logic                r_stop, r_go;
    logic signed [15:0]  r_rot, r_dist;
    // persistent state
    logic                r_stopped;
    logic signed [15:0]  r_prev_rot, r_prev_dist;
    logic [3:0]          r_same_cnt;
    // work registers
    t_action             r_act;
    logic [15:0]         r_excess;
    logic [15:0]         r_gain;
    logic                r_closer;
    logic [19:0]         r_spd;
    // output register
    logic                r_out_valid;
    logic signed [13:0]  r_right, r_left;
    logic [2:0]          r_action;

    logic                in_acc, out_free, load_out;
    logic                n_stopped;
    logic [3:0]          n_same_cnt;
    logic signed [16:0]  rot17, dist17, prot17, pdist17, band17, dlow17, dhigh17;
    logic [16:0]         rot_mag, dist_mag, prot_mag, pdist_mag;
    logic signed [17:0]  exc_tp, exc_tn, exc_fw, exc_bk;
    t_action             n_act;
    logic [15:0]         n_excess, n_gain;
    logic                n_closer;

    logic [MulAW-1:0]            mul_a;
    logic [MulBW-1:0]            mul_b;
    logic [MulSubW-1:0]          mul_sub;
    logic signed [MulResW-1:0]   mul_res;
    logic [19:0]                 spd_now;
    logic [20:0]                 scaled;
    logic signed [22:0]          spd_s, scl_s, right_w, left_w, right_c, left_c;

    tfmd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tfmd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .i_sub (mul_sub),
        .o_res (mul_res)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and output load
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:      if (in_acc) n_state = ST_DECIDE;
            ST_DECIDE:    n_state = ST_MUL_SPEED;
            ST_MUL_SPEED: n_state = ST_MUL_SCALE;
            ST_MUL_SCALE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Latch state updates and decision
    always_comb begin
        n_stopped  = (r_stopped | r_stop) & ~r_go;
        if (r_rot == r_prev_rot && r_dist == r_prev_dist) begin
            n_same_cnt = (r_same_cnt == 4'hF) ? r_same_cnt : r_same_cnt + 4'd1;
        end else begin
            n_same_cnt = 4'd0;
        end

        rot17   = 17'(r_rot);
        dist17  = 17'(r_dist);
        prot17  = 17'(r_prev_rot);
        pdist17 = 17'(r_prev_dist);
        band17  = $signed({2'b0, cfg.rotation_band});
        dlow17  = $signed({2'b0, cfg.distance_low});
        dhigh17 = $signed({2'b0, cfg.distance_high});
        rot_mag   = rot17[16]   ? 17'(-rot17)   : 17'(rot17);
        dist_mag  = dist17[16]  ? 17'(-dist17)  : 17'(dist17);
        prot_mag  = prot17[16]  ? 17'(-prot17)  : 17'(prot17);
        pdist_mag = pdist17[16] ? 17'(-pdist17) : 17'(pdist17);

        exc_tp = 18'(rot17) - 18'(band17);
        exc_tn = -18'(band17) - 18'(rot17);
        exc_fw = 18'(dist17) - 18'(dhigh17);
        exc_bk = 18'(dlow17) - 18'(dist17);

        n_excess = 16'd0;
        n_gain   = cfg.rotation_gain;
        n_closer = rot_mag < prot_mag;
        if ({1'b0, n_same_cnt} >= {1'b0, cfg.still_count_limit}) begin
            n_act = ACT_STALLED;
        end else if (rot_mag < NearZeroLsb && dist_mag < NearZeroLsb) begin
            n_act = ACT_NO_TARGET;
        end else if (n_stopped) begin
            n_act = ACT_STOPPED;
        end else if (rot17 > band17) begin
            n_act    = ACT_TURN_POS;
            n_excess = exc_tp[15:0];
        end else if (rot17 < -band17) begin
            n_act    = ACT_TURN_NEG;
            n_excess = exc_tn[15:0];
        end else if (dist17 > dhigh17) begin
            n_act    = ACT_FORWARD;
            n_excess = exc_fw[15:0];
            n_gain   = cfg.distance_gain;
            n_closer = dist_mag < pdist_mag;
        end else if (dist17 < dlow17) begin
            n_act    = ACT_BACK;
            n_excess = exc_bk[15:0];
            n_gain   = cfg.distance_gain;
            n_closer = dist_mag < pdist_mag;
        end else begin
            n_act = ACT_IN_BAND;
        end
    end

    // Hold item and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped   <= 1'b0;
            r_prev_rot  <= 16'sd0;
            r_prev_dist <= 16'sd0;
            r_same_cnt  <= 4'd0;
        end else if (r_state == ST_DECIDE) begin
            r_stopped   <= n_stopped;
            r_prev_rot  <= r_rot;
            r_prev_dist <= r_dist;
            r_same_cnt  <= n_same_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stop <= i_stop_request;
            r_go   <= i_go_request;
            r_rot  <= i_rotation;
            r_dist <= i_distance;
        end
        if (r_state == ST_DECIDE) begin
            r_act    <= n_act;
            r_excess <= n_excess;
            r_gain   <= n_gain;
            r_closer <= n_closer;
        end
        if (r_state == ST_MUL_SCALE) begin
            r_spd <= spd_now;
        end
    end

    // Feed the shared multiplier: speed pass, then right-wheel scale pass
    assign spd_now = (mul_res > 0) ? mul_res[31:FracBits] : 20'd0;

    always_comb begin
        if (r_state == ST_MUL_SCALE) begin
            mul_a   = spd_now;
            mul_b   = {7'd0, cfg.right_scale};
            mul_sub = '0;
        end else if (r_state == ST_DONE) begin
            // hold the scale product while the result waits
            mul_a   = r_spd;
            mul_b   = {7'd0, cfg.right_scale};
            mul_sub = '0;
        end else begin
            mul_a   = {4'd0, r_excess};
            mul_b   = r_gain;
            mul_sub = r_closer ? {cfg.approach_slowdown, 12'd0} : '0;
        end
    end

    // Form the wheel drive and clamp
    assign scaled = mul_res[28:8];

    always_comb begin
        spd_s = $signed({3'd0, r_spd});
        scl_s = $signed({2'd0, scaled});
        case (r_act)
            ACT_TURN_POS: begin
                right_w = -spd_s;
                left_w  = spd_s;
            end
            ACT_TURN_NEG: begin
                right_w = spd_s;
                left_w  = -spd_s;
            end
            ACT_FORWARD: begin
                right_w = scl_s;
                left_w  = spd_s;
            end
            ACT_BACK: begin
                right_w = -scl_s;
                left_w  = -spd_s;
            end
            default: begin
                right_w = 23'sd0;
                left_w  = 23'sd0;
            end
        endcase
        right_c = (right_w > Lim) ? Lim : ((right_w < -Lim) ? -Lim : right_w);
        left_c  = (left_w > Lim)  ? Lim : ((left_w < -Lim)  ? -Lim : left_w);
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_right  <= right_c[13:0];
            r_left   <= left_c[13:0];
            r_action <= r_act;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_right = r_right;
    assign o_motor_left  = r_left;
    assign o_action      = r_action;

endmodule

### hw/rtl/tfmd_regs.sv
// ----------------------------------------------------------------------------
// tfmd_regs
// APB-style configuration registers with reset defaults and read-back.
// ----------------------------------------------------------------------------
module tfmd_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfmd_pkg::RegAddrW-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output tfmd_pkg::t_cfg                  o_cfg
);
    import tfmd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[RegAddrW-1:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation_band     <= 15'd819;
            r_cfg.distance_low      <= 15'd6963;
            r_cfg.distance_high     <= 15'd8192;
            r_cfg.rotation_gain     <= 16'd5000;
            r_cfg.distance_gain     <= 16'd2500;
            r_cfg.approach_slowdown <= 16'd1000;
            r_cfg.right_scale       <= 9'd205;
            r_cfg.still_count_limit <= 4'd4;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ROT_BAND:  r_cfg.rotation_band     <= pwdata[14:0];
                REG_DIST_LOW:  r_cfg.distance_low      <= pwdata[14:0];
                REG_DIST_HIGH: r_cfg.distance_high     <= pwdata[14:0];
                REG_ROT_GAIN:  r_cfg.rotation_gain     <= pwdata[15:0];
                REG_DIST_GAIN: r_cfg.distance_gain     <= pwdata[15:0];
                REG_SLOWDOWN:  r_cfg.approach_slowdown <= pwdata[15:0];
                REG_R_SCALE:   r_cfg.right_scale       <= pwdata[8:0];
                REG_STILL_LIM: r_cfg.still_count_limit <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_ROT_BAND:  prdata = {17'd0, r_cfg.rotation_band};
            REG_DIST_LOW:  prdata = {17'd0, r_cfg.distance_low};
            REG_DIST_HIGH: prdata = {17'd0, r_cfg.distance_high};
            REG_ROT_GAIN:  prdata = {16'd0, r_cfg.rotation_gain};
            REG_DIST_GAIN: prdata = {16'd0, r_cfg.distance_gain};
            REG_SLOWDOWN:  prdata = {16'd0, r_cfg.approach_slowdown};
            REG_R_SCALE:   prdata = {23'd0, r_cfg.right_scale};
            REG_STILL_LIM: prdata = {28'd0, r_cfg.still_count_limit};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

### hw/rtl/tfmd_mul.sv
// ----------------------------------------------------------------------------
// tfmd_mul
// Shared multiply-subtract unit: registered a * b - sub, signed result.
// ----------------------------------------------------------------------------
module tfmd_mul (
    input  logic                                   i_clk,
    input  logic [tfmd_pkg::MulAW-1:0]             i_a,
    input  logic [tfmd_pkg::MulBW-1:0]             i_b,
    input  logic [tfmd_pkg::MulSubW-1:0]           i_sub,
    output logic signed [tfmd_pkg::MulResW-1:0]    o_res
);
    import tfmd_pkg::*;

    logic [MulAW+MulBW-1:0]     prod;
    logic signed [MulResW-1:0]  r_res;

    assign prod  = {{MulBW{1'b0}}, i_a} * {{MulAW{1'b0}}, i_b};
    assign o_res = r_res;

    // Register the product less the subtrahend
    always_ff @(posedge i_clk) begin
        r_res <= $signed({1'b0, prod})
               - $signed({{(MulResW-MulSubW){1'b0}}, i_sub});
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for target_follow_motor_drive. A queue-fed driver offers
// measurement items in random bursts, and a monitor stalls the result channel
// on its own pattern. Each accepted item runs through a local drive predictor
// (stop latch, unchanged-sample count, band decisions, proportional speed,
// right wheel scale, clamp). Each result is checked field by field against
// the oldest prediction. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfmd_pkg::*;

    localparam int SpeedLimit = 5000;
    localparam int CycleLimit = 300000;
    localparam int LongHold   = 400;

    typedef struct {
        logic               stop;
        logic               go;
        logic signed [15:0] rot;
        logic signed [15:0] depth;
    } t_sample;

    typedef struct {
        logic signed [13:0] right;
        logic signed [13:0] left;
        t_action            action;
    } t_drive;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [RegAddrW-1:0]       paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      stop_req = 1'b0;
    logic                      go_req = 1'b0;
    logic signed [15:0]        rotation = '0;
    logic signed [15:0]        distance = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [13:0]        motor_right;
    logic signed [13:0]        motor_left;
    logic [2:0]                action;

    // Predictor state and register copy
    t_cfg               model_cfg;
    logic               latch_stopped;
    logic signed [15:0] last_rotation;
    logic signed [15:0] last_distance;
    logic [3:0]         still_samples;

    t_sample pending_samples[$];
    t_drive  expected_drive[$];
    t_sample offered;
    int      items_queued = 0;
    int      items_accepted = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      gen_rot = 0;
    int      gen_dist = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      hold_asked = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    int      pattern_left = 0;
    int      stall_pct = 0;
    logic    offer_busy;

    target_follow_motor_drive #(
        .SPEED_LIMIT(SpeedLimit)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_stop_request (stop_req),
        .i_go_request   (go_req),
        .i_rotation     (rotation),
        .i_distance     (distance),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_motor_right  (motor_right),
        .o_motor_left   (motor_left),
        .o_action       (action)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Speed from band excess, less the slowdown while approaching
    function automatic longint excess_speed(longint excess, longint gain, logic closer);
        longint num;
        longint one;
        longint slow;
        one = longint'(1) << FracBits;
        slow = longint'(model_cfg.approach_slowdown);
        num = excess * gain;
        if (closer) begin
            num = num - slow * one;
        end
        if (num <= 0) begin
            return 0;
        end
        return num / one;
    endfunction

    function automatic longint clamp_wheel(longint v);
        if (v > SpeedLimit) begin
            return longint'(SpeedLimit);
        end
        if (v < -SpeedLimit) begin
            return -longint'(SpeedLimit);
        end
        return v;
    endfunction

    // Advance predictor state by one item and return its drive
    function automatic t_drive predict_drive(t_sample s);
        longint rot, depth, old_rot, old_dist;
        longint band, dlow, dhigh, rgain, dgain, rscale, near_lsb;
        longint rot_mag, dist_mag, spd, right, left, wheel;
        logic   rot_closer, dist_closer;
        t_drive d;
        rot = longint'(s.rot);
        depth = longint'(s.depth);
        old_rot = longint'(last_rotation);
        old_dist = longint'(last_distance);
        band = longint'(model_cfg.rotation_band);
        dlow = longint'(model_cfg.distance_low);
        dhigh = longint'(model_cfg.distance_high);
        rgain = longint'(model_cfg.rotation_gain);
        dgain = longint'(model_cfg.distance_gain);
        rscale = longint'(model_cfg.right_scale);
        near_lsb = longint'(NearZeroLsb);
        right = 0;
        left = 0;

        // Stop first, then go, so both in one item leave it running
        if (!latch_stopped && s.stop) begin
            latch_stopped = 1'b1;
        end
        if (latch_stopped && s.go) begin
            latch_stopped = 1'b0;
        end

        if (rot == old_rot && depth == old_dist) begin
            if (still_samples != 4'hF) begin
                still_samples = still_samples + 4'd1;
            end
        end else begin
            still_samples = 4'd0;
        end
        last_rotation = s.rot;
        last_distance = s.depth;

        rot_mag = (rot < 0) ? -rot : rot;
        dist_mag = (depth < 0) ? -depth : depth;
        rot_closer = rot_mag < ((old_rot < 0) ? -old_rot : old_rot);
        dist_closer = dist_mag < ((old_dist < 0) ? -old_dist : old_dist);

        if (still_samples >= model_cfg.still_count_limit) begin
            d.action = ACT_STALLED;
        end else if (rot_mag < near_lsb && dist_mag < near_lsb) begin
            d.action = ACT_NO_TARGET;
        end else if (latch_stopped) begin
            d.action = ACT_STOPPED;
        end else if (rot > band) begin
            spd = excess_speed(rot - band, rgain, rot_closer);
            right = -spd;
            left = spd;
            d.action = ACT_TURN_POS;
        end else if (rot < -band) begin
            spd = excess_speed(-band - rot, rgain, rot_closer);
            right = spd;
            left = -spd;
            d.action = ACT_TURN_NEG;
        end else if (depth > dhigh) begin
            spd = excess_speed(depth - dhigh, dgain, dist_closer);
            right = (spd * rscale) / 256;
            left = spd;
            d.action = ACT_FORWARD;
        end else if (depth < dlow) begin
            spd = excess_speed(dlow - depth, dgain, dist_closer);
            right = -((spd * rscale) / 256);
            left = -spd;
            d.action = ACT_BACK;
        end else begin
            d.action = ACT_IN_BAND;
        end

        wheel = clamp_wheel(right);
        d.right = wheel[13:0];
        wheel = clamp_wheel(left);
        d.left = wheel[13:0];
        return d;
    endfunction

    // Offer items in bursts with random gaps; predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_drive.push_back(predict_drive(offered));
                items_accepted++;
                offer_busy = 1'b0;
            end else begin
                offer_busy = in_valid;
            end
            if (!offer_busy) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    offered = pending_samples.pop_front();
                    stop_req <= offered.stop;
                    go_req <= offered.go;
                    rotation <= offered.rot;
                    distance <= offered.depth;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check results against the oldest prediction; stall on own pattern
    always @(posedge i_clk) begin
        t_drive exp_d;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
            pattern_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_drive.size() == 0) begin
                    $display("%0t: unexpected result right %0d left %0d action %0d",
                             $time, motor_right, motor_left, action);
                    fail_count++;
                end else begin
                    exp_d = expected_drive.pop_front();
                    if (motor_right !== exp_d.right) begin
                        $display("%0t: motor_right expected %0d got %0d",
                                 $time, exp_d.right, motor_right);
                        fail_count++;
                    end
                    if (motor_left !== exp_d.left) begin
                        $display("%0t: motor_left expected %0d got %0d",
                                 $time, exp_d.left, motor_left);
                        fail_count++;
                    end
                    if (action !== exp_d.action) begin
                        $display("%0t: action expected %0d got %0d",
                                 $time, exp_d.action, action);
                        fail_count++;
                    end
                end
            end

            // Long hold-off on request, else a changing stall density
            if (hold_left == 0 && hold_served != hold_asked) begin
                hold_served++;
                hold_left = LongHold;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end else begin
                    pattern_left--;
                end
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic push_sample(logic stop, logic go, int rot, int depth);
        t_sample s;
        s.stop = stop;
        s.go = go;
        s.rot = rot[15:0];
        s.depth = depth[15:0];
        gen_rot = int'(s.rot);
        gen_dist = int'(s.depth);
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // Mostly tracked targets around the bands, plus repeats, near-zero and noise
    task automatic push_random(int count);
        int   r, d, band;
        logic stop, go;
        band = int'(model_cfg.rotation_band);
        for (int n = 0; n < count; n++) begin
            stop = ($urandom_range(0, 11) == 0);
            go = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    r = $urandom;
                    d = $urandom;
                end
                1: begin
                    r = gen_rot;
                    d = gen_dist;
                end
                2: begin
                    r = int'($urandom_range(0, 120)) - 60;
                    d = int'($urandom_range(0, 120)) - 60;
                end
                3, 4, 5: begin
                    r = gen_rot + int'($urandom_range(0, 800)) - 400;
                    d = gen_dist + int'($urandom_range(0, 1600)) - 800;
                end
                default: begin
                    r = int'($urandom_range(0, 2 * band + 3000)) - band - 1500;
                    d = int'($urandom_range(0, 24000)) - 2000;
                end
            endcase
            push_sample(stop, go, r, d);
        end
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_drive.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Setup then access phase write; mirror the register into the predictor
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ROT_BAND:  model_cfg.rotation_band = value[14:0];
            REG_DIST_LOW:  model_cfg.distance_low = value[14:0];
            REG_DIST_HIGH: model_cfg.distance_high = value[14:0];
            REG_ROT_GAIN:  model_cfg.rotation_gain = value[15:0];
            REG_DIST_GAIN: model_cfg.distance_gain = value[15:0];
            REG_SLOWDOWN:  model_cfg.approach_slowdown = value[15:0];
            REG_R_SCALE:   model_cfg.right_scale = value[8:0];
            default:       model_cfg.still_count_limit = value[3:0];
        endcase
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(REG_ROT_BAND, 32'(c.rotation_band));
        write_reg(REG_DIST_LOW, 32'(c.distance_low));
        write_reg(REG_DIST_HIGH, 32'(c.distance_high));
        write_reg(REG_ROT_GAIN, 32'(c.rotation_gain));
        write_reg(REG_DIST_GAIN, 32'(c.distance_gain));
        write_reg(REG_SLOWDOWN, 32'(c.approach_slowdown));
        write_reg(REG_R_SCALE, 32'(c.right_scale));
        write_reg(REG_STILL_LIM, 32'(c.still_count_limit));
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.rotation_band = 15'($urandom_range(0, 6000));
        c.distance_low = 15'($urandom_range(0, 16000));
        if ($urandom_range(0, 4) == 0) begin
            c.distance_high = 15'($urandom_range(0, 16000));
        end else begin
            c.distance_high = 15'(32'(c.distance_low) + $urandom_range(0, 8000));
        end
        c.rotation_gain = 16'($urandom);
        c.distance_gain = 16'($urandom);
        c.approach_slowdown = 16'($urandom_range(0, 20000));
        c.right_scale = 9'($urandom_range(0, 511));
        c.still_count_limit = 4'($urandom_range(1, 15));
        return c;
    endfunction

    initial begin
        t_cfg c;
        model_cfg = '{rotation_band: 15'd819, distance_low: 15'd6963,
                      distance_high: 15'd8192, rotation_gain: 16'd5000,
                      distance_gain: 16'd2500, approach_slowdown: 16'd1000,
                      right_scale: 9'd205, still_count_limit: 4'd4};
        latch_stopped = 1'b0;
        last_rotation = '0;
        last_distance = '0;
        still_samples = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: near-zero edge, extremes, approach, stop/go, stall
        push_sample(0, 0, 0, 0);
        push_sample(0, 0, 40, -40);
        push_sample(0, 0, 41, 7500);
        push_sample(0, 0, 32767, 32767);
        push_sample(0, 0, -32768, -32768);
        push_sample(0, 0, 0, 32767);
        push_sample(0, 0, 0, -32768);
        push_sample(0, 0, 0, 20000);
        push_sample(0, 0, 0, 12000);
        push_sample(0, 0, 2000, 12000);
        push_sample(0, 0, 1500, 12000);
        push_sample(1, 0, 1500, 12000);
        push_sample(0, 0, 1000, 5000);
        push_sample(1, 1, 1000, 5000);
        push_sample(1, 1, 900, 5000);
        push_sample(0, 1, -900, 5000);
        for (int n = 0; n < 5; n++) begin
            push_sample(0, 0, -2000, 3000);
        end
        push_sample(0, 0, -2000, 3001);
        push_sample(1, 0, 20, -20);
        push_sample(0, 0, 5000, 0);
        push_sample(0, 1, 5000, 0);
        wait_drained();
        push_random(45);
        wait_drained();
        push_random(45);
        wait_drained();

        // Upper extremes, inverted distance band, right scale above unity
        c = '{rotation_band: 15'd0, distance_low: 15'd32767, distance_high: 15'd0,
              rotation_gain: 16'hFFFF, distance_gain: 16'hFFFF, approach_slowdown: 16'd0,
              right_scale: 9'h1FF, still_count_limit: 4'hF};
        apply_cfg(c);
        // Same sample long enough to saturate the unchanged count
        for (int n = 0; n < 20; n++) begin
            push_sample(0, 0, 100, 100);
        end
        push_random(100);
        wait_drained();

        // Lower extremes; a still limit of zero stalls every item
        c = '{rotation_band: 15'h7FFF, distance_low: 15'd0, distance_high: 15'h7FFF,
              rotation_gain: 16'd0, distance_gain: 16'd0, approach_slowdown: 16'hFFFF,
              right_scale: 9'd0, still_count_limit: 4'd0};
        apply_cfg(c);
        push_random(40);
        wait_drained();

        // Random settings; the first one holds off the receiver to fill the block
        for (int p = 0; p < 3; p++) begin
            apply_cfg(random_cfg());
            if (p == 0) begin
                hold_asked <= hold_asked + 1;
            end
            push_random(40);
            wait_drained();
            push_random(40);
            wait_drained();
        end

        c = '{rotation_band: 15'd400, distance_low: 15'd4000, distance_high: 15'd12000,
              rotation_gain: 16'd3000, distance_gain: 16'd3000, approach_slowdown: 16'd500,
              right_scale: 9'd256, still_count_limit: 4'd1};
        apply_cfg(c);
        push_random(60);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tfmd_pkg.sv
hw/rtl/tfmd_regs.sv
hw/rtl/tfmd_mul.sv
hw/rtl/target_follow_motor_drive.sv
verif/tb_top.sv
